### hw/rtl/b32se_pkg.sv
package b32se_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD = 1'b1;

	// alphabet codes; the unused code falls back to base32hex
	localparam logic [1:0] ALPHA_STD = 2'd0;
	localparam logic [1:0] ALPHA_HEX = 2'd1;
	localparam logic [1:0] ALPHA_CROCK = 2'd2;

	// item function codes
	localparam logic FUNC_DATA = 1'b0;
	localparam logic FUNC_CLOSE = 1'b1;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [2:0] GROUP_FULL = 3'd4;
	localparam logic [3:0] SYMS_PER_GROUP = 4'd8;

	// alphabets, first symbol in the top byte
	localparam logic [255:0] STR_STD = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
	localparam logic [255:0] STR_HEX = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
	localparam logic [255:0] STR_CROCK = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} out_t;

	// one encode job: up to five bytes, symbol count, burst length
	typedef struct packed {
		logic [39:0] value;
		logic [3:0]  syms;
		logic [3:0]  total;
		logic [1:0]  alpha;
	} job_t;

	// symbols produced by a partial group of 0..4 bytes
	function automatic logic [3:0] sym_count(input logic [2:0] n);
		logic [3:0] r;
		begin
			case (n)
				3'd1: r = 4'd2;
				3'd2: r = 4'd4;
				3'd3: r = 4'd5;
				3'd4: r = 4'd7;
				default: r = 4'd0;
			endcase
			return r;
		end
	endfunction

	// 5-bit symbol to ascii through the selected alphabet
	function automatic logic [7:0] map_symbol(input logic [1:0] alpha, input logic [4:0] idx);
		logic [7:0]   pos;
		logic [255:0] str;
		begin
			pos = 8'd255 - {idx, 3'b000};
			case (alpha)
				ALPHA_STD: str = STR_STD;
				ALPHA_CROCK: str = STR_CROCK;
				default: str = STR_HEX;
			endcase
			return str[pos -: 8];
		end
	endfunction

endpackage

### hw/rtl/b32se_front.sv
module b32se_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  b32se_pkg::in_t       item,
	input  logic [1:0]           alpha,
	input  logic                 pad,
	output logic                 job_push,
	output b32se_pkg::job_t      job
);

	logic [2:0] cnt_q;
	logic [7:0] bytes_q [4];
	logic [7:0] sel [4];
	logic       is_data;
	logic       is_fifth;
	logic [3:0] syms;

	// classify the item
	assign is_data = (item.func == b32se_pkg::FUNC_DATA);
	assign is_fifth = is_data && (cnt_q == b32se_pkg::GROUP_FULL);

	// held bytes, zero beyond the fill level
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sel[i] = (3'(i) < cnt_q) ? bytes_q[i] : 8'h00;
		end
	end

	// job build
	always_comb begin
		syms = is_fifth ? b32se_pkg::SYMS_PER_GROUP : b32se_pkg::sym_count(cnt_q);
		job.value = {sel[0], sel[1], sel[2], sel[3], is_fifth ? item.data_byte : 8'h00};
		job.syms = syms;
		job.total = (is_fifth || pad) ? b32se_pkg::SYMS_PER_GROUP : syms;
		job.alpha = alpha;
		job_push = accept && (is_fifth || (!is_data && (cnt_q != 3'd0)));
	end

	// group fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (accept) begin
			if (is_data && !is_fifth) begin
				cnt_q <= cnt_q + 3'd1;
			end else begin
				cnt_q <= 3'd0;
			end
		end
	end

	// byte store
	always_ff @(posedge clk) begin
		if (accept && is_data && !is_fifth) begin
			bytes_q[cnt_q[1:0]] <= item.data_byte;
		end
	end

endmodule

### hw/rtl/b32se_jobq.sv
module b32se_jobq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b32se_pkg::job_t wr_job,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output b32se_pkg::job_t rd_job
);

	b32se_pkg::job_t mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rd_job = mem[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

endmodule

### hw/rtl/b32se_back.sv
module b32se_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	input  b32se_pkg::job_t job,
	output logic            job_pop,
	input  logic            pop,
	output logic            empty,
	output b32se_pkg::out_t rd_data
);

	logic [39:0] val_q;
	logic [3:0]  syms_q;
	logic [3:0]  total_q;
	logic [1:0]  alpha_q;
	logic [2:0]  idx_q;
	logic        busy_q;

	b32se_pkg::out_t oq_mem [2];
	logic       oq_wr_q;
	logic       oq_rd_q;
	logic [1:0] oq_cnt_q;

	logic            emit;
	logic            done;
	logic            load;
	logic            rd_xfer;
	b32se_pkg::out_t sym;

	// symbol step control
	always_comb begin
		emit = busy_q && (oq_cnt_q != 2'd2);
		done = emit && (({1'b0, idx_q} + 4'd1) == total_q);
		load = job_valid && (!busy_q || done);
		job_pop = load;
		rd_xfer = pop && (oq_cnt_q != 2'd0);
		sym.out_char = ({1'b0, idx_q} < syms_q)
			? b32se_pkg::map_symbol(alpha_q, val_q[39:35]) : b32se_pkg::PAD_CHAR;
		sym.last = (({1'b0, idx_q} + 4'd1) == total_q);
	end

	// current job, shifted five bits per symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= 3'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q <= 3'd0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= job.value;
			syms_q <= job.syms;
			total_q <= job.total;
			alpha_q <= job.alpha;
		end else if (emit) begin
			val_q <= {val_q[34:0], 5'd0};
		end
	end

	// output queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q <= 1'b0;
			oq_rd_q <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (emit) begin
				oq_wr_q <= ~oq_wr_q;
			end
			if (rd_xfer) begin
				oq_rd_q <= ~oq_rd_q;
			end
			if (emit && !rd_xfer) begin
				oq_cnt_q <= oq_cnt_q + 2'd1;
			end else if (rd_xfer && !emit) begin
				oq_cnt_q <= oq_cnt_q - 2'd1;
			end
		end
	end

	// output queue storage
	always_ff @(posedge clk) begin
		if (emit) begin
			oq_mem[oq_wr_q] <= sym;
		end
	end

	assign empty = (oq_cnt_q == 2'd0);
	assign rd_data = oq_mem[oq_rd_q];

endmodule

### hw/rtl/base32_stream_encoder_unit.sv
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------
// input     | push / full                | wr_data  (func, data_byte)
// result    | pop / empty                | rd_data  (out_char, last)
// config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// An item is taken in every cycle while the two-entry job queue has room.
// Characters leave the symbol emitter at one per cycle while the output queue has room;
// a full group gives eight characters, so the sustained rate is set by the emitter.
// After the fifth byte or close, the job passes the job queue, emitter and output queue.
// Reset clears all control state and both config registers; cfg_ready is always high.
module base32_stream_encoder_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  b32se_pkg::in_t                       wr_data,
	output logic                                 empty,
	input  logic                                 pop,
	output b32se_pkg::out_t                      rd_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [b32se_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [b32se_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [1:0]      alpha_q;
	logic            pad_q;
	logic            accept;
	logic            job_push;
	logic            job_pop;
	logic            job_valid;
	b32se_pkg::job_t wr_job;
	b32se_pkg::job_t rd_job;

	assign cfg_ready = 1'b1;
	assign accept = push && !full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= b32se_pkg::ALPHA_STD;
			pad_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				b32se_pkg::REG_ALPHABET: alpha_q <= cfg_data[1:0];
				b32se_pkg::REG_PAD: pad_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	b32se_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (wr_data),
		.alpha    (alpha_q),
		.pad      (pad_q),
		.job_push (job_push),
		.job      (wr_job)
	);

	b32se_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (job_pop),
		.valid  (job_valid),
		.rd_job (rd_job)
	);

	b32se_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (rd_job),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.rd_data   (rd_data)
	);

endmodule

### hw/rtl/b32se_checker.sv
module b32se_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             push,
	input logic                             full,
	input b32se_pkg::in_t                   wr_data,
	input logic                             empty,
	input logic                             pop,
	input b32se_pkg::out_t                  rd_data,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [b32se_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [b32se_pkg::CFG_DATA_W-1:0] cfg_data
);

	// config writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(rd_data)))
		else $error("result changed while stalled");

	// padding runs to the end of its burst
	a_pad_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && rd_data.out_char == b32se_pkg::PAD_CHAR && !rd_data.last)
		|=> (empty || rd_data.out_char == b32se_pkg::PAD_CHAR))
		else $error("symbol after padding");

	// characters are digits, capitals or the pad
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((rd_data.out_char >= 8'h30 && rd_data.out_char <= 8'h39)
			|| (rd_data.out_char >= 8'h41 && rd_data.out_char <= 8'h5A)
			|| rd_data.out_char == b32se_pkg::PAD_CHAR))
		else $error("character outside alphabet");

endmodule

bind base32_stream_encoder_unit b32se_checker u_checker (.*);

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

	// alphabet code with no alphabet of its own, decodes as base32hex
	localparam logic [1:0] ALPHA_SPARE = 2'd3;
	localparam int TAIL_CYCLES = 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 22;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	b32se_pkg::in_t wr_data = '0;
	logic empty;
	logic pop = 1'b0;
	b32se_pkg::out_t rd_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [b32se_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [b32se_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// stimulus and expected characters
	b32se_pkg::in_t byte_q[$];
	b32se_pkg::out_t char_q[$];

	// encoder shadow state and register copies
	logic [7:0] grp[4];
	int grp_cnt = 0;
	logic [1:0] alpha_sel = b32se_pkg::ALPHA_STD;
	logic pad_on = 1'b0;

	// idling control, per phase
	bit sender_burst = 1'b0;
	bit receiver_burst = 1'b0;
	int tx_gap = 0;
	int rx_stall = 0;

	int fail_count = 0;
	int items_taken = 0;
	int chars_checked = 0;
	int groups_done = 0;
	int flushes_done = 0;
	int cfg_writes = 0;
	int cycle_count = 0;

	base32_stream_encoder_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.wr_data(wr_data),
		.empty(empty),
		.pop(pop),
		.rd_data(rd_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters still owed", cycle_count,
				char_q.size());
			$display("base32_stream_encoder_unit regression: fail");
			$finish;
		end
	end

	// 5-bit symbol to ascii for the selected alphabet
	function automatic logic [7:0] symbol_char(input logic [1:0] sel, input logic [4:0] idx);
		string std_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
		string hex_set = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
		string crock_set = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
		case (sel)
			b32se_pkg::ALPHA_STD: return std_set[idx];
			b32se_pkg::ALPHA_CROCK: return crock_set[idx];
			default: return hex_set[idx];
		endcase
	endfunction

	// update the group and queue the characters this item produces
	function automatic void encode_item(input b32se_pkg::in_t it);
		logic [39:0] bits;
		int n_bytes;
		int n_sym;
		int n_out;
		logic [7:0] b;
		b32se_pkg::out_t ch;
		bits = '0;
		if (it.func == b32se_pkg::FUNC_DATA && grp_cnt < 4) begin
			grp[grp_cnt] = it.data_byte;
			grp_cnt++;
			return;
		end
		if (it.func == b32se_pkg::FUNC_CLOSE && grp_cnt == 0)
			return;
		n_bytes = (it.func == b32se_pkg::FUNC_DATA) ? 5 : grp_cnt;
		for (int i = 0; i < 5; i++) begin
			b = (i == 4) ? it.data_byte : grp[i];
			bits = {bits[31:0], (i < n_bytes) ? b : 8'h00};
		end
		n_sym = (8 * n_bytes + 4) / 5;
		n_out = (it.func == b32se_pkg::FUNC_CLOSE && pad_on) ? 8 : n_sym;
		for (int i = 0; i < n_out; i++) begin
			ch.out_char = (i < n_sym) ? symbol_char(alpha_sel, 5'(bits >> (35 - 5 * i)))
				: b32se_pkg::PAD_CHAR;
			ch.last = (i == n_out - 1);
			char_q.push_back(ch);
		end
		if (it.func == b32se_pkg::FUNC_DATA)
			groups_done++;
		else
			flushes_done++;
		grp_cnt = 0;
	endfunction

	// compare one received character with the oldest expectation
	function automatic void check_char(input b32se_pkg::out_t got);
		b32se_pkg::out_t want;
		if (char_q.size() == 0) begin
			$error("unexpected character out_char %h last %b", got.out_char, got.last);
			fail_count++;
			return;
		end
		want = char_q.pop_front();
		chars_checked++;
		if (got.out_char !== want.out_char) begin
			$error("out_char expected %h actual %h", want.out_char, got.out_char);
			fail_count++;
		end
		if (got.last !== want.last) begin
			$error("last expected %b actual %b", want.last, got.last);
			fail_count++;
		end
	endfunction

	// input driver: one transfer per queued item, random gap between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			wr_data <= '0;
			tx_gap = 0;
		end else begin
			if (push && !full) begin
				encode_item(wr_data);
				items_taken++;
				tx_gap = sender_burst ? 0 : $urandom_range(0, 5);
			end
			if (!(push && full)) begin
				if (tx_gap > 0) begin
					tx_gap--;
					push <= 1'b0;
				end else if (byte_q.size() != 0) begin
					push <= 1'b1;
					wr_data <= byte_q.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// result monitor: check each transfer, random stall after it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			rx_stall = 0;
		end else begin
			if (pop && !empty) begin
				check_char(rd_data);
				rx_stall = receiver_burst ? 0 : $urandom_range(0, 5);
			end
			if (rx_stall > 0) begin
				rx_stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic add_item(input logic func, input logic [7:0] data_byte);
		b32se_pkg::in_t it;
		it.func = func;
		it.data_byte = data_byte;
		byte_q.push_back(it);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// wait until every item is taken and every character has come out
	task automatic wait_idle();
		do @(posedge clk);
		while (byte_q.size() != 0 || push || char_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// write both registers back to back, valid held across the pair
	task automatic write_cfg(input logic [1:0] sel, input logic pad);
		logic spare_bit;
		spare_bit = 1'($urandom_range(0, 1));
		cfg_valid <= 1'b1;
		cfg_index <= b32se_pkg::REG_ALPHABET;
		cfg_data <= sel;
		do @(posedge clk);
		while (!cfg_ready);
		alpha_sel = sel;
		cfg_index <= b32se_pkg::REG_PAD;
		cfg_data <= {spare_bit, pad};
		do @(posedge clk);
		while (!cfg_ready);
		pad_on = pad;
		cfg_valid <= 1'b0;
		cfg_writes += 2;
	endtask

	// random traffic: mostly whole or partial groups, some stray items
	task automatic queue_random(input int want);
		int added;
		int n;
		added = 0;
		while (added < want) begin
			n = $urandom_range(0, 9);
			if (n <= 4) begin
				for (int k = 0; k < n; k++)
					add_item(b32se_pkg::FUNC_DATA, rand_byte());
				add_item(b32se_pkg::FUNC_CLOSE, rand_byte());
				added += n + 1;
			end else if (n <= 7) begin
				for (int k = 0; k < 5 * (n - 4); k++)
					add_item(b32se_pkg::FUNC_DATA, rand_byte());
				added += 5 * (n - 4);
			end else begin
				add_item(logic'($urandom_range(0, 1)), rand_byte());
				added++;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// directed: empty close, all-ones group, one-byte flush
		sender_burst = 1'b1;
		receiver_burst = 1'b1;
		write_cfg(b32se_pkg::ALPHA_STD, 1'b0);
		add_item(b32se_pkg::FUNC_CLOSE, 8'hFF);
		for (int k = 0; k < 5; k++)
			add_item(b32se_pkg::FUNC_DATA, 8'hFF);
		add_item(b32se_pkg::FUNC_DATA, 8'h00);
		add_item(b32se_pkg::FUNC_CLOSE, 8'h00);
		wait_idle();

		// directed: two and four byte flushes with padding
		sender_burst = 1'b0;
		write_cfg(b32se_pkg::ALPHA_HEX, 1'b1);
		add_item(b32se_pkg::FUNC_DATA, 8'hA5);
		add_item(b32se_pkg::FUNC_DATA, 8'h5A);
		add_item(b32se_pkg::FUNC_CLOSE, 8'hFF);
		for (int k = 0; k < 4; k++)
			add_item(b32se_pkg::FUNC_DATA, rand_byte());
		add_item(b32se_pkg::FUNC_CLOSE, rand_byte());
		wait_idle();

		// directed: three byte flush without padding, crockford letters
		receiver_burst = 1'b0;
		write_cfg(b32se_pkg::ALPHA_CROCK, 1'b0);
		add_item(b32se_pkg::FUNC_DATA, 8'h84);
		add_item(b32se_pkg::FUNC_DATA, 8'h21);
		add_item(b32se_pkg::FUNC_DATA, 8'hFF);
		add_item(b32se_pkg::FUNC_CLOSE, 8'h00);
		wait_idle();

		// directed: spare alphabet code, one byte padded out
		write_cfg(ALPHA_SPARE, 1'b1);
		add_item(b32se_pkg::FUNC_DATA, 8'hF8);
		add_item(b32se_pkg::FUNC_CLOSE, 8'h7E);
		wait_idle();

		// random phases over every alphabet and padding combination
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			sender_burst = ($urandom_range(0, 3) == 0);
			receiver_burst = ($urandom_range(0, 3) == 0);
			write_cfg(2'(p % 4), logic'((p / 4) % 2));
			queue_random(ITEMS_PER_PHASE);
			wait_idle();
		end

		$display("%0d items taken, %0d characters checked (%0d full groups, %0d flushes)",
			items_taken, chars_checked, groups_done, flushes_done);
		$display("%0d register writes over all four alphabet codes, padding on and off",
			cfg_writes);
		if (fail_count == 0)
			$display("base32_stream_encoder_unit regression: pass");
		else
			$display("base32_stream_encoder_unit regression: fail");
		$finish;
	end

endmodule
